// File: hdl/tbc_pkg.sv
package tbc_pkg;

  localparam int QW = 52;
  localparam int RW = 37;
  localparam int CW = 17;
  localparam int PW = 34;
  localparam int KW = 35;
  localparam int WW = 24;

  localparam logic signed [WW-1:0] WMAX = 24'sh7FFFFF;
  localparam logic signed [WW-1:0] WMIN = -24'sh800000;

  typedef struct packed {
    logic          valid;
    logic [QW-1:0] num_v;
    logic [QW-1:0] num_w;
    logic [RW-1:0] rem_v;
    logic [RW-1:0] rem_w;
    logic [QW-1:0] quo_v;
    logic [QW-1:0] quo_w;
    logic [RW-1:0] den;
    logic          neg_v;
    logic          neg_w;
    logic          zero;
    logic          degen;
  } tbc_lane_t;

endpackage

// File: hdl/tbc_div_cell.sv
module tbc_div_cell
  import tbc_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      en,
  input  tbc_lane_t din,
  output tbc_lane_t dout
);

  logic [RW-1:0] r_v;
  logic [RW-1:0] r_w;
  logic          q_v;
  logic          q_w;
  tbc_lane_t     dout_next;

  always_comb begin
    r_v = {din.rem_v[RW-2:0], din.num_v[QW-1]};
    r_w = {din.rem_w[RW-2:0], din.num_w[QW-1]};
    q_v = (r_v >= din.den);
    q_w = (r_w >= din.den);
    dout_next       = din;
    dout_next.num_v = {din.num_v[QW-2:0], 1'b0};
    dout_next.num_w = {din.num_w[QW-2:0], 1'b0};
    dout_next.rem_v = q_v ? (r_v - din.den) : r_v;
    dout_next.rem_w = q_w ? (r_w - din.den) : r_w;
    dout_next.quo_v = {din.quo_v[QW-2:0], q_v};
    dout_next.quo_w = {din.quo_w[QW-2:0], q_w};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else if (en) begin
      dout <= dout_next;
    end
  end

endmodule

// File: hdl/triangle_barycentric_coords.sv
// Pipeline: 5 set-up stages, one divider cell per quotient bit over 52 cells,
// and the output register, from an accepted item to its result.
// Throughput: one item per cycle; the whole pipeline stalls only while a
// result waits at the output. Reset is synchronous and clears all valid bits
// and the degenerate limit register.
module triangle_barycentric_coords
  import tbc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic signed [15:0]   point_x,
  input  logic signed [15:0]   point_y,
  input  logic signed [15:0]   vert_a_x,
  input  logic signed [15:0]   vert_a_y,
  input  logic signed [15:0]   vert_b_x,
  input  logic signed [15:0]   vert_b_y,
  input  logic signed [15:0]   vert_c_x,
  input  logic signed [15:0]   vert_c_y,
  input  logic                 degenerate_limit_we,
  input  logic [31:0]          degenerate_limit,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic signed [WW-1:0] weight_a,
  output logic signed [WW-1:0] weight_c,
  output logic                 degenerate,
  output logic                 saturated
);

  logic en;
  logic [31:0] limit;

  logic va, vb, vc, vd;
  logic signed [CW-1:0] e0x, e0y, e1x, e1y, qx, qy;
  logic signed [PW-1:0] p1, p2, p3, p4, p5, p6;
  logic signed [KW-1:0] k, c12, c02;
  logic signed [KW-1:0] kabs;
  logic [PW-1:0] kmag, nv, nw;
  logic [63:0] ksq;
  logic big, neg_v, neg_w, zero;
  tbc_lane_t lane [QW+1];

  logic signed [QW+1:0] sv, sw;
  logic signed [QW+3:0] su;
  logic sat_a, sat_c;

  assign en = !out_valid || out_ready;
  assign in_ready = en;
  assign kabs = k[KW-1] ? -k : k;

  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= '0;
    end else if (degenerate_limit_we) begin
      limit <= degenerate_limit;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e0x <= CW'(vert_c_x) - CW'(vert_a_x);
      e0y <= CW'(vert_c_y) - CW'(vert_a_y);
      e1x <= CW'(vert_b_x) - CW'(vert_a_x);
      e1y <= CW'(vert_b_y) - CW'(vert_a_y);
      qx  <= CW'(point_x) - CW'(vert_a_x);
      qy  <= CW'(point_y) - CW'(vert_a_y);
      p1 <= PW'(e1x) * PW'(e0y);
      p2 <= PW'(e1y) * PW'(e0x);
      p3 <= PW'(e1x) * PW'(qy);
      p4 <= PW'(e1y) * PW'(qx);
      p5 <= PW'(e0x) * PW'(qy);
      p6 <= PW'(e0y) * PW'(qx);
      k   <= KW'(p1) - KW'(p2);
      c12 <= KW'(p3) - KW'(p4);
      c02 <= KW'(p5) - KW'(p6);
      kmag  <= PW'(kabs);
      nv    <= PW'(c12[KW-1] ? -c12 : c12);
      nw    <= PW'(c02[KW-1] ? -c02 : c02);
      ksq   <= 64'(kabs[31:0]) * 64'(kabs[31:0]);
      big   <= (kabs[KW-1:32] != '0);
      neg_v <= c12[KW-1] ^ k[KW-1];
      neg_w <= (c02 > 0) ^ k[KW-1];
      zero  <= (k == '0);
    end
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
      vc <= 1'b0;
      vd <= 1'b0;
    end else if (en) begin
      va <= in_valid;
      vb <= va;
      vc <= vb;
      vd <= vc;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lane[0].num_v <= {1'b0, nv, 17'b0} + QW'(kmag);
      lane[0].num_w <= {1'b0, nw, 17'b0} + QW'(kmag);
      lane[0].rem_v <= '0;
      lane[0].rem_w <= '0;
      lane[0].quo_v <= '0;
      lane[0].quo_w <= '0;
      lane[0].den   <= {2'b0, kmag, 1'b0};
      lane[0].neg_v <= neg_v;
      lane[0].neg_w <= neg_w;
      lane[0].zero  <= zero;
      lane[0].degen <= !big && (ksq <= 64'(limit));
    end
    if (rst) begin
      lane[0].valid <= 1'b0;
    end else if (en) begin
      lane[0].valid <= vd;
    end
  end

  for (genvar i = 0; i < QW; i++) begin : g_cell
    tbc_div_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .en   (en),
      .din  (lane[i]),
      .dout (lane[i+1])
    );
  end

  always_comb begin
    sv = lane[QW].neg_v ? -$signed({2'b0, lane[QW].quo_v})
                        :  $signed({2'b0, lane[QW].quo_v});
    sw = lane[QW].neg_w ? -$signed({2'b0, lane[QW].quo_w})
                        :  $signed({2'b0, lane[QW].quo_w});
    su = (QW+4)'(65536) - (QW+4)'(sv) - (QW+4)'(sw);
    sat_a = (su > (QW+4)'(WMAX)) || (su < (QW+4)'(WMIN));
    sat_c = (sv > (QW+2)'(WMAX)) || (sv < (QW+2)'(WMIN));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      degenerate <= lane[QW].degen;
      if (lane[QW].zero) begin
        weight_a  <= '0;
        weight_c  <= '0;
        saturated <= 1'b0;
      end else begin
        weight_a  <= sat_a ? (su[QW+3] ? WMIN : WMAX) : WW'(su);
        weight_c  <= sat_c ? (sv[QW+1] ? WMIN : WMAX) : WW'(sv);
        saturated <= sat_a || sat_c;
      end
    end
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= lane[QW].valid;
    end
  end

  a_reset_clears: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");
  a_sat_clips: assert property (@(posedge clk) disable iff (rst)
    out_valid && saturated |-> weight_a == WMAX || weight_a == WMIN ||
    weight_c == WMAX || weight_c == WMIN)
    else $error("saturation flag without a clipped weight");

endmodule

// File: sim/bary_checker.sv
`timescale 1ns / 100ps

module bary_checker
  import tbc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  logic signed [15:0]   point_x,
  input  logic signed [15:0]   point_y,
  input  logic signed [15:0]   vert_a_x,
  input  logic signed [15:0]   vert_a_y,
  input  logic signed [15:0]   vert_b_x,
  input  logic signed [15:0]   vert_b_y,
  input  logic signed [15:0]   vert_c_x,
  input  logic signed [15:0]   vert_c_y,
  input  logic                 degenerate_limit_we,
  input  logic [31:0]          degenerate_limit,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  logic signed [WW-1:0] weight_a,
  input  logic signed [WW-1:0] weight_c,
  input  logic                 degenerate,
  input  logic                 saturated,
  output int                   errors,
  output int                   pending
);

  typedef struct packed {
    logic signed [WW-1:0] wa;
    logic signed [WW-1:0] wc;
    logic                 degen;
    logic                 sat;
  } weights_t;

  weights_t    expected_weights[$];
  logic [31:0] limit_copy;

  function automatic longint round_quotient(longint num, longint den);
    longint n;
    longint d;
    longint q;
    n = (num < 0) ? -num : num;
    d = (den < 0) ? -den : den;
    q = (2 * n + d) / (2 * d);
    return (((num < 0) != (den < 0)) ? -q : q);
  endfunction

  function automatic weights_t barycentric(
    longint px, longint py, longint ax, longint ay,
    longint bx, longint by, longint cx, longint cy);
    weights_t r;
    longint   e0x, e0y, e1x, e1y, qx, qy, k, c12, c02, v, w, u, kmag;
    e0x = cx - ax; e0y = cy - ay;
    e1x = bx - ax; e1y = by - ay;
    qx  = px - ax; qy  = py - ay;
    k   = e1x * e0y - e1y * e0x;
    c12 = e1x * qy - e1y * qx;
    c02 = e0x * qy - e0y * qx;
    kmag = (k < 0) ? -k : k;
    r = '0;
    if (kmag >= 64'sh1_0000_0000) begin
      r.degen = 1'b0;
    end else begin
      r.degen = ($unsigned(kmag) * $unsigned(kmag)) <= {32'd0, limit_copy};
    end
    if (k != 0) begin
      v = round_quotient(c12 * 65536, k);
      w = round_quotient(-c02 * 65536, k);
      u = 65536 - v - w;
      if (u > 8388607) begin
        r.wa = WMAX; r.sat = 1'b1;
      end else if (u < -8388608) begin
        r.wa = WMIN; r.sat = 1'b1;
      end else begin
        r.wa = u[WW-1:0];
      end
      if (v > 8388607) begin
        r.wc = WMAX; r.sat = 1'b1;
      end else if (v < -8388608) begin
        r.wc = WMIN; r.sat = 1'b1;
      end else begin
        r.wc = v[WW-1:0];
      end
    end
    return r;
  endfunction

  assign pending = expected_weights.size();

  always @(posedge clk) begin
    weights_t exp_w;
    if (rst) begin
      limit_copy <= '0;
      errors     <= 0;
      expected_weights.delete();
    end else begin
      if (degenerate_limit_we) begin
        limit_copy <= degenerate_limit;
      end
      if (in_valid && in_ready) begin
        expected_weights.push_back(barycentric(point_x, point_y, vert_a_x, vert_a_y,
                                               vert_b_x, vert_b_y, vert_c_x, vert_c_y));
      end
      if (out_valid && out_ready) begin
        if (expected_weights.size() == 0) begin
          $display("%0t: unexpected item wa=%0d wc=%0d", $time, weight_a, weight_c);
          errors <= errors + 1;
        end else begin
          exp_w = expected_weights.pop_front();
          if (exp_w.wa !== weight_a || exp_w.wc !== weight_c ||
              exp_w.degen !== degenerate || exp_w.sat !== saturated) begin
            $display({"%0t: expected wa=%0d wc=%0d degen=%0b sat=%0b, ",
                      "got wa=%0d wc=%0d degen=%0b sat=%0b"},
                     $time, exp_w.wa, exp_w.wc, exp_w.degen, exp_w.sat,
                     weight_a, weight_c, degenerate, saturated);
            errors <= errors + 1;
          end
        end
      end
    end
  end

endmodule

// File: sim/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import tbc_pkg::*;

  logic                 clk;
  logic                 rst;
  logic                 in_valid;
  logic                 in_ready;
  logic signed [15:0]   coord[8];
  logic                 degenerate_limit_we;
  logic [31:0]          degenerate_limit;
  logic                 out_valid;
  logic                 out_ready;
  logic signed [WW-1:0] weight_a;
  logic signed [WW-1:0] weight_c;
  logic                 degenerate;
  logic                 saturated;
  int                   errors;
  int                   pending;
  int                   cycle_count;
  bit                   stall_enable;

  triangle_barycentric_coords u_top (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .point_x(coord[0]), .point_y(coord[1]), .vert_a_x(coord[2]), .vert_a_y(coord[3]),
    .vert_b_x(coord[4]), .vert_b_y(coord[5]), .vert_c_x(coord[6]), .vert_c_y(coord[7]),
    .degenerate_limit_we(degenerate_limit_we), .degenerate_limit(degenerate_limit),
    .out_valid(out_valid), .out_ready(out_ready), .weight_a(weight_a),
    .weight_c(weight_c), .degenerate(degenerate), .saturated(saturated)
  );

  bary_checker u_checker (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .point_x(coord[0]), .point_y(coord[1]), .vert_a_x(coord[2]), .vert_a_y(coord[3]),
    .vert_b_x(coord[4]), .vert_b_y(coord[5]), .vert_c_x(coord[6]), .vert_c_y(coord[7]),
    .degenerate_limit_we(degenerate_limit_we), .degenerate_limit(degenerate_limit),
    .out_valid(out_valid), .out_ready(out_ready), .weight_a(weight_a),
    .weight_c(weight_c), .degenerate(degenerate), .saturated(saturated),
    .errors(errors), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic int gap_length();
    if ($urandom_range(0, 9) < 8) begin
      return $urandom_range(0, 2);
    end
    return $urandom_range(5, 40);
  endfunction

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 600000) begin
      $display("[triangle_barycentric_coords] ERROR");
      $finish;
    end
  end

  initial begin : result_side
    int gap;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_enable && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        gap = gap_length();
        repeat (gap) @(negedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  task automatic send_triangle(input logic signed [15:0] c[8]);
    int gap;
    if (stall_enable && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      gap = gap_length();
      repeat (gap) @(negedge clk);
    end
    for (int i = 0; i < 8; i++) coord[i] <= c[i];
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_limit(input logic [31:0] value);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (70) @(posedge clk);
    @(negedge clk);
    degenerate_limit <= value;
    degenerate_limit_we <= 1'b1;
    @(negedge clk);
    degenerate_limit_we <= 1'b0;
  endtask

  function automatic logic signed [15:0] random_coord(int mode);
    case (mode)
      0: return 16'($urandom());
      1: return 16'($signed($urandom_range(0, 64)) - 32);
      2: return ($urandom_range(0, 1) != 0) ? 16'sh7FFF : -16'sh8000;
      default: return 16'($signed($urandom_range(0, 2000)) - 1000);
    endcase
  endfunction

  initial begin : stimulus
    logic signed [15:0] c[8];
    logic [31:0] limits[6];
    int mode;
    limits = '{32'd0, 32'hFFFF_FFFF, 32'd100, 32'd1000000, 32'h8000_0000, 32'd1};
    rst = 1'b1;
    in_valid = 1'b0;
    out_ready = 1'b0;
    degenerate_limit_we = 1'b0;
    degenerate_limit = '0;
    cycle_count = 0;
    stall_enable = 1'b0;
    for (int i = 0; i < 8; i++) coord[i] = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed cases at full rate: unit triangle, zero area, extremes, far point.
    c = '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd10, 16'sd0, 16'sd0, 16'sd10};
    send_triangle(c);
    c = '{16'sd3, 16'sd3, 16'sd0, 16'sd0, 16'sd10, 16'sd0, 16'sd0, 16'sd10};
    send_triangle(c);
    c = '{16'sd5, 16'sd5, 16'sd1, 16'sd1, 16'sd1, 16'sd1, 16'sd1, 16'sd1};
    send_triangle(c);
    c = '{16'sd7, 16'sd2, 16'sd0, 16'sd0, 16'sd2, 16'sd2, 16'sd4, 16'sd4};
    send_triangle(c);
    c = '{16'sh7FFF, 16'sh7FFF, -16'sh8000, -16'sh8000, 16'sh7FFF, -16'sh8000,
          -16'sh8000, 16'sh7FFF};
    send_triangle(c);
    c = '{-16'sh8000, 16'sh7FFF, 16'sh7FFF, -16'sh8000, -16'sh8000, -16'sh8000,
          16'sh7FFF, 16'sh7FFF};
    send_triangle(c);
    c = '{16'sh7FFF, 16'sh7FFF, 16'sd0, 16'sd0, 16'sd1, 16'sd0, 16'sd0, 16'sd1};
    send_triangle(c);
    c = '{-16'sh8000, 16'sh7FFF, 16'sd0, 16'sd0, 16'sd1, 16'sd0, 16'sd1, 16'sd1};
    send_triangle(c);
    c = '{16'sd1, 16'sd1, 16'sd0, 16'sd0, 16'sd3, 16'sd0, 16'sd0, 16'sd3};
    send_triangle(c);
    c = '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd1, 16'sd1, 16'sd0};
    send_triangle(c);

    stall_enable = 1'b1;
    for (int phase = 0; phase < 6; phase++) begin
      write_limit(limits[phase]);
      for (int n = 0; n < 225; n++) begin
        mode = $urandom_range(0, 3);
        for (int i = 0; i < 8; i++) c[i] = random_coord(mode);
        if ($urandom_range(0, 15) == 0) begin
          c[6] = c[4]; c[7] = c[5];
        end
        send_triangle(c);
      end
    end
    in_valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (70) @(posedge clk);
    if (errors == 0) begin
      $display("[triangle_barycentric_coords] OK");
    end else begin
      $display("[triangle_barycentric_coords] ERROR");
    end
    $finish;
  end

endmodule
